>>> src/mts8_pkg.sv
// ----------------------------------------------------------------------------
// mts8_pkg
// Shared types and constants for the midtones stretch to 8-bit pipeline.
// ----------------------------------------------------------------------------
package mts8_pkg;

    // configuration register widths
    localparam int unsigned LVL_W  = 17;
    localparam int unsigned GAIN_W = 40;
    localparam int unsigned MID_W  = 33;
    localparam int unsigned CFG_W  = 40;
    localparam int unsigned IDX_W  = 3;

    // sample and product widths
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned HALF_W  = GAIN_W / 2;
    localparam int unsigned PLO_W   = PIX_W + HALF_W;
    localparam int unsigned PHI_W   = PIX_W + HALF_W + 1;
    localparam int unsigned NUM_W   = PIX_W + GAIN_W + 1;
    localparam int unsigned DEN_W   = NUM_W + 1;
    localparam int unsigned QUO_W   = 9;
    localparam int unsigned SHIFT_W = DEN_W + QUO_W - 1;

    // output levels
    localparam logic [7:0] LEVEL_BLACK = 8'd0;
    localparam logic [7:0] LEVEL_WHITE = 8'd255;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SHADOW    = 3'd0;
    localparam logic [IDX_W-1:0] REG_HIGHLIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_NUM  = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_DEN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIDTONE   = 3'd4;

    // reset values
    localparam logic [LVL_W-1:0]  RST_SHADOW    = 17'd0;
    localparam logic [LVL_W-1:0]  RST_HIGHLIGHT = 17'd65536;
    localparam logic [GAIN_W-1:0] RST_GAIN_NUM  = 40'hFFFF808000;
    localparam logic [GAIN_W-1:0] RST_GAIN_DEN  = 40'd0;
    localparam logic [MID_W-1:0]  RST_MIDTONE   = 33'h080000000;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic        last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] display_level;
        logic       last_level;
    } t_out_item;

    typedef struct packed {
        logic [LVL_W-1:0]         shadow_level;
        logic [LVL_W-1:0]         highlight_level;
        logic signed [GAIN_W-1:0] gain_numerator;
        logic signed [GAIN_W-1:0] gain_denominator;
        logic [MID_W-1:0]         midtone_balance;
    } t_cfg;

    // numerator and denominator handed from the front end to the divider
    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic                    below;
        logic                    above;
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
    } t_nd;

endpackage

>>> src/mts8_cfg.sv
// ----------------------------------------------------------------------------
// mts8_cfg
// Configuration register file with index decode and reset values.
// ----------------------------------------------------------------------------
module mts8_cfg import mts8_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shadow_level     <= RST_SHADOW;
            r_cfg.highlight_level  <= RST_HIGHLIGHT;
            r_cfg.gain_numerator   <= RST_GAIN_NUM;
            r_cfg.gain_denominator <= RST_GAIN_DEN;
            r_cfg.midtone_balance  <= RST_MIDTONE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SHADOW:    r_cfg.shadow_level     <= i_cfg_data[LVL_W-1:0];
                REG_HIGHLIGHT: r_cfg.highlight_level  <= i_cfg_data[LVL_W-1:0];
                REG_GAIN_NUM:  r_cfg.gain_numerator   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_DEN:  r_cfg.gain_denominator <= i_cfg_data[GAIN_W-1:0];
                REG_MIDTONE:   r_cfg.midtone_balance  <= i_cfg_data[MID_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/mts8_front.sv
// ----------------------------------------------------------------------------
// mts8_front
// Three stages: level compare and offset, split partial products, and
// assembly of the numerator and denominator.
// ----------------------------------------------------------------------------
module mts8_front import mts8_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_nd      o_nd
);

    // stage 1 registers
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic                   r_s1_below;
    logic                   r_s1_above;
    logic [SAMPLE_BITS-1:0] r_s1_x;

    // stage 2 registers
    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic                    r_s2_below;
    logic                    r_s2_above;
    logic [PLO_W-1:0]        r_s2_nlo;
    logic signed [PHI_W-1:0] r_s2_nhi;
    logic [PLO_W-1:0]        r_s2_dlo;
    logic signed [PHI_W-1:0] r_s2_dhi;

    // stage 3 register
    t_nd r_nd;

    logic [SAMPLE_BITS-1:0]  w_pix;
    logic [LVL_W-1:0]        w_pix_ext;
    logic [LVL_W-1:0]        w_diff;
    logic [PIX_W-1:0]        w_x16;
    logic [PLO_W-1:0]        n_nlo;
    logic signed [PHI_W-1:0] n_nhi;
    logic [PLO_W-1:0]        n_dlo;
    logic signed [PHI_W-1:0] n_dhi;
    logic [NUM_W-1:0]        n_num;
    logic [DEN_W-1:0]        n_den;

    // level compare and offset from the shadow level
    assign w_pix     = i_item.pixel_value[SAMPLE_BITS-1:0];
    assign w_pix_ext = LVL_W'(w_pix);
    assign w_diff    = w_pix_ext - i_cfg.shadow_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_last  <= i_item.last_pixel;
            r_s1_below <= w_pix_ext < i_cfg.shadow_level;
            r_s1_above <= w_pix_ext >= i_cfg.highlight_level;
            r_s1_x     <= w_diff[SAMPLE_BITS-1:0];
        end
    end

    // partial products on the low unsigned and high signed gain halves
    assign w_x16 = PIX_W'(r_s1_x);
    assign n_nlo = w_x16 * i_cfg.gain_numerator[HALF_W-1:0];
    assign n_nhi = $signed({1'b0, w_x16}) * $signed(i_cfg.gain_numerator[GAIN_W-1:HALF_W]);
    assign n_dlo = w_x16 * i_cfg.gain_denominator[HALF_W-1:0];
    assign n_dhi = $signed({1'b0, w_x16})
                 * $signed(i_cfg.gain_denominator[GAIN_W-1:HALF_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_last  <= r_s1_last;
            r_s2_below <= r_s1_below;
            r_s2_above <= r_s1_above;
            r_s2_nlo   <= n_nlo;
            r_s2_nhi   <= n_nhi;
            r_s2_dlo   <= n_dlo;
            r_s2_dhi   <= n_dhi;
        end
    end

    // recombine halves, subtract the midtone balance from the denominator
    assign n_num = {r_s2_nhi, {HALF_W{1'b0}}} + NUM_W'(r_s2_nlo);
    assign n_den = {r_s2_dhi[PHI_W-1], r_s2_dhi, {HALF_W{1'b0}}} + DEN_W'(r_s2_dlo)
                 - DEN_W'(i_cfg.midtone_balance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd.valid <= 1'b0;
        end else if (i_en) begin
            r_nd.valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nd.last  <= r_s2_last;
            r_nd.below <= r_s2_below;
            r_nd.above <= r_s2_above;
            r_nd.num   <= n_num;
            r_nd.den   <= n_den;
        end
    end

    assign o_nd = r_nd;

endmodule

>>> src/mts8_div.sv
// ----------------------------------------------------------------------------
// mts8_div
// Sign and special case stage followed by a pipelined restoring divider,
// one quotient bit per stage, with saturation to the 8-bit level range.
// ----------------------------------------------------------------------------
module mts8_div import mts8_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_nd       i_nd,
    output logic      o_valid,
    output t_out_item o_res
);

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             fix;
        logic [7:0]       fix_level;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } t_div_st;

    t_div_st r_st [0:QUO_W];
    t_div_st n_st0;

    logic w_num_neg;
    logic w_den_neg;
    logic w_num_zero;
    logic w_den_zero;

    // magnitudes and the cases that need no division
    assign w_num_neg  = i_nd.num[NUM_W-1];
    assign w_den_neg  = i_nd.den[DEN_W-1];
    assign w_num_zero = (i_nd.num == '0);
    assign w_den_zero = (i_nd.den == '0);

    always_comb begin
        n_st0.valid     = i_nd.valid;
        n_st0.last      = i_nd.last;
        n_st0.rem       = w_num_neg ? NUM_W'(-i_nd.num) : NUM_W'(i_nd.num);
        n_st0.dvs       = w_den_neg ? DEN_W'(-i_nd.den) : DEN_W'(i_nd.den);
        n_st0.quo       = '0;
        n_st0.fix       = 1'b1;
        n_st0.fix_level = LEVEL_BLACK;
        if (i_nd.below) begin
            n_st0.fix_level = LEVEL_BLACK;
        end else if (i_nd.above) begin
            n_st0.fix_level = LEVEL_WHITE;
        end else if (w_den_zero) begin
            n_st0.fix_level = (!w_num_neg && !w_num_zero) ? LEVEL_WHITE : LEVEL_BLACK;
        end else if (w_num_zero || (w_num_neg != w_den_neg)) begin
            n_st0.fix_level = LEVEL_BLACK;
        end else begin
            n_st0.fix = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].valid <= 1'b0;
        end else if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int unsigned BIT_POS = QUO_W - 1 - k;

        logic [SHIFT_W-1:0] w_rem_ext;
        logic [SHIFT_W-1:0] w_sub;
        logic [SHIFT_W-1:0] w_diff;
        logic               w_ge;
        t_div_st            n_st;

        assign w_rem_ext = SHIFT_W'(r_st[k].rem);
        assign w_sub     = SHIFT_W'(r_st[k].dvs) << BIT_POS;
        assign w_ge      = (w_rem_ext >= w_sub);
        assign w_diff    = w_rem_ext - w_sub;

        always_comb begin
            n_st     = r_st[k];
            n_st.rem = w_ge ? w_diff[NUM_W-1:0] : r_st[k].rem;
            n_st.quo = {r_st[k].quo[QUO_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k+1].valid <= 1'b0;
            end else if (i_en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    // final level with clamp for quotients of 256 and above
    always_comb begin
        o_res.last_level = r_st[QUO_W].last;
        if (r_st[QUO_W].fix) begin
            o_res.display_level = r_st[QUO_W].fix_level;
        end else if (r_st[QUO_W].quo[QUO_W-1]) begin
            o_res.display_level = LEVEL_WHITE;
        end else begin
            o_res.display_level = r_st[QUO_W].quo[7:0];
        end
    end

    assign o_valid = r_st[QUO_W].valid;

endmodule

>>> src/midtones_stretch_to_8bit.sv
// ----------------------------------------------------------------------------
// midtones_stretch_to_8bit
// Midtones transfer function stretch of linear samples to 8-bit levels.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_valid / o_stall carry one pixel (value and last flag)
//   per transaction. Output channel: o_valid / i_stall carry one display
//   level with its last flag. Each pixel gives exactly one level, in order.
//   Throughput is one pixel per cycle while the receiver does not stall.
//   Between the input transaction and o_valid lie 14 register stages:
//   three front stages (offset, partial products, numerator/denominator),
//   one sign stage, nine restoring divider stages (one quotient bit each)
//   and the output register. The divider depth sets the latency.
//   When the receiver stalls with a level pending, the whole pipeline
//   freezes and o_stall is raised; nothing is dropped or repeated.
//   Reset clears all valid bits and loads the default register values.
//   Configuration is written through i_cfg_wr_en / i_cfg_index /
//   i_cfg_data while no pixel is in flight.
// ----------------------------------------------------------------------------
module midtones_stretch_to_8bit import mts8_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_item         i_pixel,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_level,
    input  logic             i_cfg_wr_en,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_nd       w_nd;
    logic      w_en;
    logic      w_res_valid;
    t_out_item w_res;
    logic      r_out_valid;
    t_out_item r_out;

    // pipeline advances unless a held result is stalled
    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    mts8_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mts8_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_pixel),
        .i_cfg   (w_cfg),
        .o_nd    (w_nd)
    );

    mts8_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_nd    (w_nd),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_level = r_out;

    // stall only ever comes from a pending result
    a_stall_needs_result: assert property (@(posedge i_clk)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised without a pending result");

    // a frozen pipeline keeps the divider input unchanged
    a_frozen_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_nd))
        else $error("front stage moved while stalled");

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_valid && !w_nd.valid))
        else $error("valid bits not cleared by reset");

endmodule

>>> sim/midtones_stretch_checker.sv
// ----------------------------------------------------------------------------
// midtones_stretch_checker
// Watches the pixel, level and register ports of midtones_stretch_to_8bit.
// Every accepted pixel is stretched here with the register values seen on
// the write port. The expected level is queued. Each accepted level is
// compared with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midtones_stretch_checker import mts8_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_pixel,
    input  logic             i_out_valid,
    input  logic             i_stall,
    input  t_out_item        i_level,
    input  logic             i_cfg_wr_en,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    t_cfg      stretch_cfg;
    t_out_item level_q[$];
    int        error_count = 0;

    // stretch one pixel to its display level under the given registers
    function automatic t_out_item stretch_pixel(input t_cfg c, input t_in_item p);
        t_out_item r;
        longint    span;
        longint    kn;
        longint    kd;
        longint    mid;
        longint    num;
        longint    den;
        longint    quo;
        r.last_level = p.last_pixel;
        // shadow test comes first, so it wins when shadow sits above highlight
        if (p.pixel_value < c.shadow_level) begin
            r.display_level = LEVEL_BLACK;
        end else if (p.pixel_value >= c.highlight_level) begin
            r.display_level = LEVEL_WHITE;
        end else begin
            span = longint'(p.pixel_value) - longint'(c.shadow_level);
            kn   = $signed(c.gain_numerator);
            kd   = $signed(c.gain_denominator);
            mid  = longint'(c.midtone_balance);
            num  = span * kn;
            den  = span * kd - mid;
            // zero denominator: white only for a positive numerator
            if (den == 0) begin
                r.display_level = (num > 0) ? LEVEL_WHITE : LEVEL_BLACK;
            end else begin
                quo = num / den;
                if (quo < 0) begin
                    r.display_level = LEVEL_BLACK;
                end else if (quo > 255) begin
                    r.display_level = LEVEL_WHITE;
                end else begin
                    r.display_level = quo[7:0];
                end
            end
        end
        return r;
    endfunction

    // register shadow copy, prediction queue and level comparison
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            stretch_cfg.shadow_level     = RST_SHADOW;
            stretch_cfg.highlight_level  = RST_HIGHLIGHT;
            stretch_cfg.gain_numerator   = RST_GAIN_NUM;
            stretch_cfg.gain_denominator = RST_GAIN_DEN;
            stretch_cfg.midtone_balance  = RST_MIDTONE;
            level_q.delete();
        end else begin
            // register writes; unknown indexes are dropped
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SHADOW:    stretch_cfg.shadow_level     = i_cfg_data[LVL_W-1:0];
                    REG_HIGHLIGHT: stretch_cfg.highlight_level  = i_cfg_data[LVL_W-1:0];
                    REG_GAIN_NUM:  stretch_cfg.gain_numerator   = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_DEN:  stretch_cfg.gain_denominator = i_cfg_data[GAIN_W-1:0];
                    REG_MIDTONE:   stretch_cfg.midtone_balance  = i_cfg_data[MID_W-1:0];
                    default: ;
                endcase
            end
            // pixel transaction
            if (i_valid && !i_in_stall) begin
                level_q.push_back(stretch_pixel(stretch_cfg, i_pixel));
            end
            // level transaction
            if (i_out_valid && !i_stall) begin
                if (level_q.size() == 0) begin
                    $error("display_level: expected none, actual %0d (last_level %0d)",
                           i_level.display_level, i_level.last_level);
                    error_count++;
                end else begin
                    want = level_q.pop_front();
                    if (i_level.display_level !== want.display_level) begin
                        $error("display_level: expected %0d, actual %0d",
                               want.display_level, i_level.display_level);
                        error_count++;
                    end
                    if (i_level.last_level !== want.last_level) begin
                        $error("last_level: expected %0d, actual %0d",
                               want.last_level, i_level.last_level);
                        error_count++;
                    end
                end
            end
        end
        o_pending <= level_q.size();
        o_errors  <= error_count;
    end

endmodule

>>> sim/tb_midtones_stretch_to_8bit.sv
// ----------------------------------------------------------------------------
// tb_midtones_stretch_to_8bit
// Drives pixels and register settings into midtones_stretch_to_8bit.
// A directed pass covers the reset values, the black and white points,
// shadow above highlight, zero denominators and extreme gains. Random
// passes follow with proper stretch curves and raw register values, under
// rotating sender idle and receiver stall rates. Checking is done by
// midtones_stretch_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_midtones_stretch_to_8bit;
    import mts8_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RAND_PASSES  = 12;
    localparam int PASS_PIXELS  = 34;

    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [CFG_W-1:0] GAIN_MAX    = 40'h7F_FFFF_FFFF;
    localparam logic [CFG_W-1:0] GAIN_MIN    = 40'h80_0000_0000;
    localparam logic [CFG_W-1:0] FIX_ONE     = 40'h01_0000_0000;
    localparam logic [CFG_W-1:0] FIX_NEG_ONE = 40'hFF_0000_0000;
    localparam logic [CFG_W-1:0] DEF_GAIN    = RST_GAIN_NUM;
    localparam logic [CFG_W-1:0] DEF_MID     = {7'd0, RST_MIDTONE};
    localparam longint           ONE_FIX     = 64'sd4294967296;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    t_in_item         i_pixel;
    logic             o_valid;
    logic             i_stall;
    t_out_item        o_level;
    logic             i_cfg_wr_en;
    logic [IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    int level_errors;
    int levels_pending;
    int cycle_count   = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int cur_shadow    = 0;
    int cur_highlight = 65536;
    int idle_plan[4]  = '{0, 55, 0, 16};
    int stall_plan[4] = '{0, 0, 55, 16};

    midtones_stretch_to_8bit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_level     (o_level),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    midtones_stretch_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_stall  (o_stall),
        .i_pixel     (i_pixel),
        .i_out_valid (o_valid),
        .i_stall     (i_stall),
        .i_level     (o_level),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (level_errors),
        .o_pending   (levels_pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("midtones_stretch_to_8bit: mismatch");
            $finish;
        end
    end

    function automatic logic [CFG_W-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_W-1:0];
    endfunction

    // mostly inside the stretch window, sometimes anywhere
    function automatic logic [15:0] rand_pixel();
        int top;
        top = ((cur_highlight > 65536) ? 65536 : cur_highlight) - 1;
        if (cur_shadow <= top && $urandom_range(9) < 7) begin
            return 16'($urandom_range(top, cur_shadow));
        end
        return 16'($urandom);
    endfunction

    // one pixel transaction, with random idle cycles ahead of it
    task automatic send_pixel(input logic [15:0] value, input logic last);
        t_in_item p;
        p.pixel_value = value;
        p.last_pixel  = last;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop sending and let every level come out
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (levels_pending != 0) @(posedge i_clk);
    endtask

    // write all five registers back to back, then junk to an unused index
    task automatic write_settings(input logic [CFG_W-1:0] shd, input logic [CFG_W-1:0] hil,
                                  input logic [CFG_W-1:0] kn, input logic [CFG_W-1:0] kd,
                                  input logic [CFG_W-1:0] mid);
        logic [CFG_W-1:0] vals[6];
        logic [IDX_W-1:0] idx[6];
        vals = '{shd, hil, kn, kd, mid, rand_word()};
        idx  = '{REG_SHADOW, REG_HIGHLIGHT, REG_GAIN_NUM, REG_GAIN_DEN, REG_MIDTONE,
                 REG_SPARE};
        for (int i = 0; i < 6; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en   <= 1'b0;
        cur_shadow    = int'(shd[LVL_W-1:0]);
        cur_highlight = int'(hil[LVL_W-1:0]);
    endtask

    // a proper stretch curve: random black point, white point and balance
    task automatic write_curve_settings();
        longint shd;
        longint rng;
        longint hil;
        longint mid;
        longint kn;
        longint kd;
        shd = $urandom_range(0, 30000);
        rng = $urandom_range(2, 65536 - int'(shd));
        hil = shd + rng;
        mid = longint'($urandom);
        kn  = ((mid - ONE_FIX) * 255) / rng;
        kd  = (2 * mid - ONE_FIX) / rng;
        write_settings(shd[CFG_W-1:0], hil[CFG_W-1:0], kn[CFG_W-1:0], kd[CFG_W-1:0],
                       mid[CFG_W-1:0]);
    endtask

    // stimulus
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pixel     <= '0;
        i_stall     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_SHADOW;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: full-range curve with balance one half
        send_pixel(16'd0, 1'b0);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'hAAAA, 1'b1);
        send_pixel(16'h5555, 1'b0);

        // black and white points on both sides of their edges
        settle();
        write_settings(40'd1000, 40'd60000, DEF_GAIN, 40'd0, DEF_MID);
        send_pixel(16'd999, 1'b0);
        send_pixel(16'd1000, 1'b0);
        send_pixel(16'd59999, 1'b1);
        send_pixel(16'd60000, 1'b0);

        // shadow above highlight
        settle();
        write_settings(40'd40000, 40'd20000, DEF_GAIN, 40'd0, DEF_MID);
        send_pixel(16'd10000, 1'b0);
        send_pixel(16'd30000, 1'b0);
        send_pixel(16'd50000, 1'b1);

        // zero denominator at one pixel, negative and oversized quotients nearby
        settle();
        write_settings(40'd0, 40'd65536, FIX_ONE, 40'h00_0040_0000, FIX_ONE);
        send_pixel(16'd1024, 1'b0);
        send_pixel(16'd1023, 1'b0);
        send_pixel(16'd2048, 1'b1);

        // zero denominator everywhere, numerator zero or negative
        settle();
        write_settings(40'd0, 40'd65536, FIX_NEG_ONE, 40'd0, 40'd0);
        send_pixel(16'd0, 1'b0);
        send_pixel(16'd5, 1'b1);

        // extreme gains and balances
        settle();
        write_settings(40'd0, 40'd65536, GAIN_MIN, GAIN_MAX, FIX_ONE);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'd1, 1'b1);
        settle();
        write_settings(40'd0, 40'd65536, GAIN_MAX, GAIN_MIN, 40'd0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'd1, 1'b1);

        // extreme black and white points
        settle();
        write_settings(40'd65536, 40'd65536, DEF_GAIN, 40'd0, DEF_MID);
        send_pixel(16'hFFFF, 1'b1);
        settle();
        write_settings(40'd0, 40'd0, DEF_GAIN, 40'd0, DEF_MID);
        send_pixel(16'd0, 1'b0);

        // random passes under rotating idle and stall rates
        for (int s = 0; s < RAND_PASSES; s++) begin
            settle();
            idle_pct  = idle_plan[s % 4];
            stall_pct = stall_plan[s % 4];
            if ($urandom_range(9) < 7) begin
                write_curve_settings();
            end else begin
                write_settings(40'($urandom_range(0, 65536)), 40'($urandom_range(0, 65536)),
                               rand_word(), rand_word(), rand_word());
            end
            repeat (PASS_PIXELS) send_pixel(rand_pixel(), $urandom_range(7) == 0);
        end

        // drain and verdict
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (levels_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (level_errors == 0 && levels_pending == 0) begin
            $display("midtones_stretch_to_8bit: match");
        end else begin
            $display("midtones_stretch_to_8bit: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/mts8_pkg.sv
src/mts8_cfg.sv
src/mts8_front.sv
src/mts8_div.sv
src/midtones_stretch_to_8bit.sv
sim/midtones_stretch_checker.sv
sim/tb_midtones_stretch_to_8bit.sv
